// ===== sv/tdsb_pkg.sv =====
// ----------------------------------------------------------------------------
// tdsb_pkg
// Shared types and constants of the TDM slot DC blocker with statistics.
// ----------------------------------------------------------------------------
`default_nettype none
package tdsb_pkg;
    localparam int NSLOT = 4;
    // statistics widths are sized for this window length
    localparam int MAX_WINDOW_FRAMES = 1024;
    localparam logic [1:0] CFG_VOICE_SLOT = 2'd0;
    localparam logic [1:0] CFG_DC_COEF    = 2'd1;
    localparam logic [1:0] CFG_STATS_PER  = 2'd2;
    localparam logic       KIND_SAMPLE    = 1'b0;
    localparam logic       KIND_STATS     = 1'b1;
    localparam logic [15:0] COEF_RESET    = 16'd65208;
    localparam logic [7:0]  PERIOD_RESET  = 8'd50;
    localparam logic [9:0]  XING_MAX      = 10'd1023;

    typedef struct packed {
        logic [15:0] s0;
        logic [15:0] s1;
        logic [15:0] s2;
        logic [15:0] s3;
        logic        window_last;
    } t_in_word;

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  stat_channel;
        logic [15:0] filtered_sample;
        logic [15:0] channel_mean;
        logic [15:0] channel_rms;
        logic [15:0] channel_minimum;
        logic [15:0] channel_maximum;
        logic [9:0]  zero_crossings;
        logic        last_result;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input word
        logic filt;      // filter multiply stage
        logic acc;       // accumulate statistics, finish filter
        logic div_start; // start divide/sqrt for channel
        logic [1:0] ch;  // channel for report
        logic clr;       // clear window stats
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_busy;
        logic report;    // window end with report due
        logic wlast;
    } t_sts;
endpackage
`default_nettype wire

// ===== sv/tdsb_if.sv =====
// ----------------------------------------------------------------------------
// tdsb_if
// Valid/ready channel carrying one word.
// ----------------------------------------------------------------------------
`default_nettype none
interface tdsb_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/tdm_slot_dc_blocker_with_stats.sv =====
// ----------------------------------------------------------------------------
// tdm_slot_dc_blocker_with_stats
// DC blocker on a chosen TDM slot with per-channel window statistics.
// ----------------------------------------------------------------------------
// Input channel: one word per four-slot TDM frame plus window_last.
// Output channel: one filtered voice sample per frame, then on every
// stats_period-th window end one statistics word per channel; last_result
// marks the final word caused by a frame.
// A frame passes through load, multiply, accumulate and output register steps;
// the sample word waits for the output register while the sink stalls.
// Every window end adds a clear step. A reporting window end then runs,
// per channel, through the shared serial divider / square-root unit
// (start, 41 divide steps, 21 root steps, hand-off, send).
// Reset restores the registers to their defaults and clears filter and
// statistics state. One output register holds the pending word; when the
// sink stalls, at most one further frame is taken in and its word waits in the
// datapath, after which no frame is accepted until the sink drains.
// Configuration writes are taken in any cycle via i_cfg_we/idx/data.
// ----------------------------------------------------------------------------
`default_nettype none
module tdm_slot_dc_blocker_with_stats
    import tdsb_pkg::*;
#(
    parameter int CHANNELS = 4
)(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tdsb_if.sink             in_ch,
    tdsb_if.source           out_ch,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    logic [1:0]  r_voice;
    logic [15:0] r_coef;
    logic [7:0]  r_period;
    t_cmd w_cmd;
    t_sts w_sts;
    logic [15:0] w_sample;
    t_out_word w_stat, r_out;
    logic w_samp_cap, w_cap;

    function automatic t_out_word sample_word(logic [15:0] s, t_sts st);
        t_out_word w;
        w = '0;
        w.result_kind = KIND_SAMPLE;
        w.filtered_sample = s;
        w.last_result = !(st.wlast && st.report);
        return w;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice <= '0; r_coef <= COEF_RESET; r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VOICE_SLOT: r_voice <= i_cfg_data[1:0];
                CFG_DC_COEF:    r_coef <= i_cfg_data;
                CFG_STATS_PER:  r_period <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    tdsb_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (in_ch.valid), .o_in_ready (in_ch.ready),
        .o_out_valid (out_ch.valid), .i_out_ready (out_ch.ready),
        .o_samp_cap (w_samp_cap), .o_stat_cap (w_cap),
        .i_sts (w_sts), .o_cmd (w_cmd)
    );

    tdsb_datapath #(.CHANNELS(CHANNELS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd (w_cmd), .i_in (t_in_word'(in_ch.data)),
        .i_voice_slot (r_voice), .i_coef (r_coef), .i_period (r_period),
        .o_sts (w_sts), .o_sample (w_sample), .o_stat (w_stat)
    );

    // output register: sample word after accumulate, stats on send
    always_ff @(posedge i_clk) begin
        if (w_cap) begin
            r_out <= w_stat;
        end else if (w_samp_cap) begin
            r_out <= sample_word(w_sample, w_sts);
        end
    end
    assign out_ch.data = r_out;
endmodule
`default_nettype wire

// ===== sv/tdsb_divsqrt.sv =====
// ----------------------------------------------------------------------------
// tdsb_divsqrt
// Serial unit: signed sum / n, unsigned sumsq / n, then floor square root.
// ----------------------------------------------------------------------------
`default_nettype none
module tdsb_divsqrt
    import tdsb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [26:0] i_sum,
    input  wire logic [40:0] i_sumsq,
    input  wire logic [10:0] i_n,
    output logic             o_busy,
    output logic [15:0]      o_mean,
    output logic [15:0]      o_rms
);
    typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT} t_st;
    t_st r_st;
    logic [5:0]  r_cnt;
    logic [40:0] r_q;      // sumsq quotient, then sqrt radicand
    logic [40:0] r_rem;
    logic [26:0] r_mq;
    logic [26:0] r_mrem;
    logic        r_neg;
    logic [10:0] r_n;
    logic [20:0] r_root;
    logic [22:0] r_srem;

    logic [41:0] w_rem2;
    logic [27:0] w_mrem2;
    logic [24:0] w_trial;
    logic [24:0] w_sr2;
    logic [26:0] w_abs;
    assign w_abs   = i_sum[26] ? (~i_sum + 27'd1) : i_sum;
    assign w_rem2  = {r_rem, r_q[40]};
    assign w_mrem2 = {r_mrem, r_mq[26]};
    // two radicand bits per step
    assign w_sr2   = {r_srem, r_q[40:39]};
    assign w_trial = {2'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        r_q <= i_sumsq;
                        r_rem <= '0;
                        r_mq <= w_abs;
                        r_mrem <= '0;
                        r_neg <= i_sum[26];
                        r_n <= (i_n == '0) ? 11'd1 : i_n;
                        r_cnt <= 6'd0;
                        r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    // restoring division, one bit each
                    if (w_rem2 >= {31'd0, r_n}) begin
                        r_rem <= 41'(w_rem2 - {31'd0, r_n});
                        r_q <= {r_q[39:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2[40:0];
                        r_q <= {r_q[39:0], 1'b0};
                    end
                    if (r_cnt < 6'd27) begin
                        if (w_mrem2 >= {17'd0, r_n}) begin
                            r_mrem <= 27'(w_mrem2 - {17'd0, r_n});
                            r_mq <= {r_mq[25:0], 1'b1};
                        end else begin
                            r_mrem <= w_mrem2[26:0];
                            r_mq <= {r_mq[25:0], 1'b0};
                        end
                    end
                    if (r_cnt == 6'd40) begin
                        r_cnt <= '0;
                        r_root <= '0;
                        r_srem <= '0;
                        r_st <= S_SQRT;
                        o_mean <= r_neg ? 16'(~r_mq + 27'd1) : r_mq[15:0];
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_SQRT: begin
                    // radicand has 41 bits: first step takes a leading zero
                    if (r_cnt == 6'd0) begin
                        r_q <= {r_q[39:0], 1'b0};
                        if ({24'd0, r_q[40]} >= 25'd1) begin
                            r_srem <= '0;
                            r_root <= 21'd1;
                        end else begin
                            r_root <= '0;
                            r_srem <= '0;
                        end
                        r_cnt <= 6'd1;
                    end else begin
                        r_q <= {r_q[38:0], 2'b00};
                        if (w_sr2 >= w_trial) begin
                            r_srem <= 23'(w_sr2 - w_trial);
                            r_root <= {r_root[19:0], 1'b1};
                        end else begin
                            r_srem <= w_sr2[22:0];
                            r_root <= {r_root[19:0], 1'b0};
                        end
                        if (r_cnt == 6'd20) begin
                            r_st <= S_IDLE;
                        end
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
    assign o_busy = (r_st != S_IDLE);
    assign o_rms  = r_root[15:0];
endmodule
`default_nettype wire

// ===== sv/tdsb_datapath.sv =====
// ----------------------------------------------------------------------------
// tdsb_datapath
// Filter, statistics registers and report formatting.
// ----------------------------------------------------------------------------
`default_nettype none
module tdsb_datapath
    import tdsb_pkg::*;
#(
    parameter int CHANNELS = 4
)(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire t_in_word   i_in,
    input  wire logic [1:0] i_voice_slot,
    input  wire logic [15:0] i_coef,
    input  wire logic [7:0] i_period,
    output t_sts            o_sts,
    output logic [15:0]     o_sample,
    output t_out_word       o_stat
);
    localparam int NCH = (CHANNELS < NSLOT) ? CHANNELS : NSLOT;
    localparam int FW = 17;
    localparam logic [FW-1:0] MAXF = FW'(MAX_WINDOW_FRAMES);
    localparam logic signed [47:0] YMAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] YMIN = {1'b1, {47{1'b0}}};

    logic signed [15:0] r_x [NSLOT];
    logic r_wl;
    logic signed [15:0] r_xprev;
    logic signed [47:0] r_y;
    logic signed [64:0] r_prod;
    logic signed [15:0] r_xv;
    logic [7:0] r_wcnt;
    logic [FW-1:0] r_frames;
    logic signed [26:0] r_sum [NSLOT];
    logic [40:0] r_sq [NSLOT];
    logic signed [15:0] r_min [NSLOT];
    logic signed [15:0] r_max [NSLOT];
    logic [9:0] r_xing [NSLOT];
    logic signed [15:0] r_prev [NSLOT];
    logic [31:0] r_sqv [NSLOT];
    logic r_report;
    // snapshot for report
    logic signed [26:0] r_ssum [NSLOT];
    logic [40:0] r_ssq [NSLOT];
    logic signed [15:0] r_smin [NSLOT];
    logic signed [15:0] r_smax [NSLOT];
    logic [9:0] r_sxing [NSLOT];
    logic [10:0] r_sn;

    logic signed [49:0] w_y;
    logic signed [47:0] w_ysat;
    logic signed [47:0] w_t;
    logic signed [15:0] w_out;
    logic w_room;
    logic w_busy;
    logic [15:0] w_mean, w_rms;

    // y = (x - xprev)*2^16 + floor(R*yprev/2^16); prod registered
    assign w_y = 50'(r_prod >>> 16) + ({{18{r_xv[15]}}, r_xv, 16'd0}
               - {{18{r_xprev[15]}}, r_xprev, 16'd0});
    assign w_ysat = (w_y > 50'(YMAX)) ? YMAX : (w_y < 50'(YMIN)) ? YMIN : w_y[47:0];
    // truncate toward zero
    assign w_t = (w_ysat[47] && (w_ysat[15:0] != 16'd0)) ? (w_ysat >>> 16) + 48'sd1
               : (w_ysat >>> 16);
    assign w_out = (w_t > 48'sd32767) ? 16'sh7fff : (w_t < -48'sd32768) ? 16'sh8000
                 : w_t[15:0];
    assign w_room = (r_frames < MAXF);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x[0] <= i_in.s0; r_x[1] <= i_in.s1;
            r_x[2] <= i_in.s2; r_x[3] <= i_in.s3;
            r_wl <= i_in.window_last;
        end
        if (i_cmd.filt) begin
            r_prod <= $signed({1'b0, i_coef}) * r_y;
            r_xv <= r_x[i_voice_slot];
            for (int c = 0; c < NSLOT; c++) r_sqv[c] <= 32'(r_x[c]) * 32'(r_x[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xprev <= '0;
            r_y <= '0;
            r_wcnt <= '0;
            r_frames <= '0;
            r_report <= 1'b0;
            for (int c = 0; c < NSLOT; c++) begin
                r_sum[c] <= '0; r_sq[c] <= '0; r_min[c] <= 16'sh7fff;
                r_max[c] <= 16'sh8000; r_xing[c] <= '0; r_prev[c] <= '0;
            end
        end else if (i_cmd.acc) begin
            r_xprev <= r_xv;
            r_y <= w_ysat;
            o_sample <= w_out;
            r_report <= 1'b0;
            if (w_room) begin
                for (int c = 0; c < NCH; c++) begin
                    r_sum[c] <= r_sum[c] + 27'(r_x[c]);
                    r_sq[c] <= r_sq[c] + 41'(r_sqv[c]);
                    if (r_x[c] < r_min[c]) r_min[c] <= r_x[c];
                    if (r_x[c] > r_max[c]) r_max[c] <= r_x[c];
                    if (r_frames != '0 && (r_prev[c][15] != r_x[c][15])
                        && r_xing[c] != XING_MAX)
                        r_xing[c] <= r_xing[c] + 10'd1;
                    r_prev[c] <= r_x[c];
                end
                r_frames <= r_frames + FW'(1);
            end
            if (r_wl) begin
                if (r_wcnt + 8'd1 >= i_period) begin
                    r_wcnt <= '0;
                    r_report <= 1'b1;
                end else begin
                    r_wcnt <= r_wcnt + 8'd1;
                end
            end
        end else if (i_cmd.clr) begin
            r_frames <= '0;
            for (int c = 0; c < NSLOT; c++) begin
                r_ssum[c] <= r_sum[c]; r_ssq[c] <= r_sq[c];
                r_smin[c] <= r_min[c]; r_smax[c] <= r_max[c]; r_sxing[c] <= r_xing[c];
                r_sum[c] <= '0; r_sq[c] <= '0; r_min[c] <= 16'sh7fff;
                r_max[c] <= 16'sh8000; r_xing[c] <= '0; r_prev[c] <= '0;
            end
            r_sn <= 11'(r_frames);
        end
    end

    tdsb_divsqrt u_div (
        .i_clk, .i_rst_n,
        .i_start (i_cmd.div_start),
        .i_sum   (r_ssum[i_cmd.ch]),
        .i_sumsq (r_ssq[i_cmd.ch]),
        .i_n     (r_sn),
        .o_busy  (w_busy),
        .o_mean  (w_mean),
        .o_rms   (w_rms)
    );

    always_comb begin
        o_stat = '0;
        o_stat.result_kind = KIND_STATS;
        o_stat.stat_channel = i_cmd.ch;
        o_stat.channel_mean = w_mean;
        o_stat.channel_rms = w_rms;
        o_stat.channel_minimum = r_smin[i_cmd.ch];
        o_stat.channel_maximum = r_smax[i_cmd.ch];
        o_stat.zero_crossings = r_sxing[i_cmd.ch];
        o_stat.last_result = (32'(i_cmd.ch) == NCH - 1);
    end
    assign o_sts = '{div_busy: w_busy, report: r_report, wlast: r_wl};
endmodule
`default_nettype wire

// ===== sv/tdsb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdsb_ctrl
// Sequencer: frame load, filter, accumulate, then optional report per channel.
// ----------------------------------------------------------------------------
`default_nettype none
module tdsb_ctrl
    import tdsb_pkg::*;
#(
    parameter int CHANNELS = 4
)(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output logic       o_samp_cap,
    output logic       o_stat_cap,
    input  wire t_sts  i_sts,
    output t_cmd       o_cmd
);
    localparam int NCH = (CHANNELS < NSLOT) ? CHANNELS : NSLOT;
    typedef enum logic [2:0] {S_IDLE, S_FILT, S_ACC, S_SAMP, S_CLR,
                              S_START, S_WAIT, S_SEND} t_st;
    t_st r_st;
    logic [1:0] r_ch;
    logic r_out_valid;
    logic w_fire;
    logic w_samp_cap;
    logic w_send;
    assign w_fire = r_out_valid && i_out_ready;
    // sample word goes to the output register once it is free
    assign w_samp_cap = (r_st == S_SAMP) && (!r_out_valid || w_fire);
    assign w_send = (r_st == S_SEND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ch <= '0; r_out_valid <= 1'b0;
        end else begin
            if (w_samp_cap || w_send) r_out_valid <= 1'b1;
            else if (w_fire) r_out_valid <= 1'b0;
            case (r_st)
                S_IDLE: if (i_in_valid) r_st <= S_FILT;
                S_FILT: r_st <= S_ACC;
                S_ACC: r_st <= S_SAMP;
                S_SAMP: begin
                    if (w_samp_cap) begin
                        r_st <= i_sts.wlast ? S_CLR : S_IDLE;
                    end
                end
                S_CLR: begin
                    r_ch <= '0;
                    r_st <= i_sts.report ? S_START : S_IDLE;
                end
                S_START: r_st <= S_WAIT;
                S_WAIT: if (!i_sts.div_busy && (!r_out_valid || w_fire)) r_st <= S_SEND;
                S_SEND: begin
                    if (32'(r_ch) == NCH - 1) begin
                        r_st <= S_IDLE;
                    end else begin
                        r_ch <= r_ch + 2'd1; r_st <= S_START;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.load = (r_st == S_IDLE) && i_in_valid;
        o_cmd.filt = (r_st == S_FILT);
        o_cmd.acc = (r_st == S_ACC);
        o_cmd.clr = (r_st == S_CLR);
        o_cmd.div_start = (r_st == S_START);
        o_cmd.ch = r_ch;
    end
    assign o_in_ready = (r_st == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_samp_cap = w_samp_cap;
    assign o_stat_cap = w_send;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && i_in_valid |=> !o_in_ready) else $error("double accept");
    a_send_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_SEND |-> !r_out_valid || w_fire) else $error("result overwritten");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_START |-> !i_sts.div_busy) else $error("divider busy at start");
endmodule
`default_nettype wire
